// ===== rtl/core/ncipmm_pkg.sv =====
// ----------------------------------------------------------------------------
// ncipmm_pkg: shared types and constants for the SET_CONFIG PMm rewriter
// Item structs, walk phase codes, register indexes and PMm byte selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ncipmm_pkg;

  // field and state widths
  localparam int DATA_W    = 8;
  localparam int LEN_W     = 16;
  localparam int POS_W     = 16;
  localparam int END_W     = 9;   // payload end, at most 3 + 255
  localparam int HDR_W     = 10;  // parameter header position
  localparam int SPAN_W    = 11;  // header position plus 2 plus value length
  localparam int PMM_W     = 64;
  localparam int PMM_BYTES = 8;
  localparam int PMM_IDX_W = 3;
  localparam int CFG_IDX_W = 1;

  // command framing
  localparam logic [DATA_W-1:0] CMD_GID       = 8'h20;
  localparam logic [DATA_W-1:0] CMD_OID_SETCF = 8'h02;
  localparam logic [LEN_W-1:0]  MIN_PKT_LEN   = 16'd5;
  localparam logic [END_W-1:0]  HDR_BYTES     = 9'd3;
  localparam logic [HDR_W-1:0]  FIRST_PARAM   = 10'd4;

  // parameter ids and limits
  localparam logic [DATA_W-1:0] ID_PMM_DIRECT = 8'h51;
  localparam logic [DATA_W-1:0] ID_PMM_TAIL   = 8'h40;
  localparam logic [DATA_W-1:0] TAIL_MIN_LEN  = 8'h12;

  localparam logic [PMM_W-1:0] PMM_RESET = 64'h00F1_0000_0001_4300;
  localparam logic [POS_W-1:0] POS_MAX   = '1;

  // parameter list walk
  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN  = 2'd1,
    PH_DONE = 2'd2
  } walk_phase_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATCH_ENABLE = 1'b0,
    REG_PMM_VALUE    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic [LEN_W-1:0]  packet_length;
    logic              end_of_packet;
  } cmd_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_byte;
    logic              out_last;
    logic              was_patched;
  } res_item_t;

  // PMm byte k, byte 0 in the top bits
  function automatic logic [DATA_W-1:0] pmm_byte(input logic [PMM_W-1:0] pmm,
                                                 input logic [PMM_IDX_W-1:0] k);
    logic [5:0] sh;
    sh = {3'd7 - k, 3'b000};
    return pmm[sh +: DATA_W];
  endfunction

endpackage

// ===== rtl/core/ncipmm_walk.sv =====
// ----------------------------------------------------------------------------
// ncipmm_walk: packet tracker and parameter list walker
// Holds per-packet state, decides qualification, walks parameter headers
// and substitutes PMm bytes. One item is processed per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncipmm_walk (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  step,
  input  ncipmm_pkg::cmd_item_t                 item,
  input  logic                                  patch_enable,
  input  logic [ncipmm_pkg::PMM_W-1:0]          pmm_value,
  output ncipmm_pkg::res_item_t                 result
);

  logic [ncipmm_pkg::POS_W-1:0]  byte_position, byte_position_next;
  logic [ncipmm_pkg::END_W-1:0]  payload_end, payload_end_next;
  logic                          packet_qualifies, packet_qualifies_next;
  ncipmm_pkg::walk_phase_t       walk_phase, walk_phase_next;
  logic [ncipmm_pkg::HDR_W-1:0]  next_header_position, next_header_position_next;
  logic [ncipmm_pkg::DATA_W-1:0] current_id, current_id_next;
  logic [ncipmm_pkg::HDR_W-1:0]  replace_start, replace_start_next;
  logic                          replace_active, replace_active_next;
  logic                          patched_flag, patched_flag_next;

  logic [ncipmm_pkg::POS_W-1:0]  rs_pos, rs_end, hdr_pos, rs_off;
  logic [ncipmm_pkg::SPAN_W-1:0] vstart, vend, pend_ext;
  logic [ncipmm_pkg::END_W-1:0]  lim;
  logic [ncipmm_pkg::DATA_W-1:0] b, ob;

  // per-item decode and state update
  always_comb begin
    b        = item.data_byte;
    ob       = b;
    rs_pos   = ncipmm_pkg::POS_W'(replace_start);
    rs_end   = rs_pos + ncipmm_pkg::POS_W'(ncipmm_pkg::PMM_BYTES);
    rs_off   = byte_position - rs_pos;
    hdr_pos  = ncipmm_pkg::POS_W'(next_header_position);
    vstart   = ncipmm_pkg::SPAN_W'(next_header_position) + 11'd2;
    vend     = vstart + ncipmm_pkg::SPAN_W'(b);
    pend_ext = ncipmm_pkg::SPAN_W'(payload_end);
    lim      = ncipmm_pkg::HDR_BYTES + ncipmm_pkg::END_W'(b);

    payload_end_next          = payload_end;
    packet_qualifies_next     = packet_qualifies;
    walk_phase_next           = walk_phase;
    next_header_position_next = next_header_position;
    current_id_next           = current_id;
    replace_start_next        = replace_start;
    replace_active_next       = replace_active;
    patched_flag_next         = patched_flag;

    if (byte_position == 16'd0) begin
      packet_qualifies_next = patch_enable &&
                              (item.packet_length >= ncipmm_pkg::MIN_PKT_LEN) &&
                              (b == ncipmm_pkg::CMD_GID);
    end else if (byte_position == 16'd1) begin
      if (b != ncipmm_pkg::CMD_OID_SETCF) begin
        packet_qualifies_next = 1'b0;
      end
    end else if (byte_position == 16'd2) begin
      // list end: min(length, 3 + declared payload length)
      if (item.packet_length < ncipmm_pkg::LEN_W'(lim)) begin
        payload_end_next = item.packet_length[ncipmm_pkg::END_W-1:0];
      end else begin
        payload_end_next = lim;
      end
    end else if (packet_qualifies) begin
      // substitution window
      if (replace_active && byte_position >= rs_pos && byte_position < rs_end) begin
        ob = ncipmm_pkg::pmm_byte(pmm_value, rs_off[ncipmm_pkg::PMM_IDX_W-1:0]);
        if (byte_position + 16'd1 == rs_end) begin
          replace_active_next = 1'b0;
        end
      end
      // header walk
      if (walk_phase == ncipmm_pkg::PH_ID && byte_position == hdr_pos) begin
        if (vstart <= pend_ext) begin
          current_id_next = b;
          walk_phase_next = ncipmm_pkg::PH_LEN;
        end else begin
          walk_phase_next = ncipmm_pkg::PH_DONE;
        end
      end else if (walk_phase == ncipmm_pkg::PH_LEN && byte_position == hdr_pos + 16'd1) begin
        if (vend > pend_ext) begin
          walk_phase_next = ncipmm_pkg::PH_DONE;
        end else begin
          if (current_id == ncipmm_pkg::ID_PMM_DIRECT &&
              b >= ncipmm_pkg::DATA_W'(ncipmm_pkg::PMM_BYTES)) begin
            replace_start_next  = vstart[ncipmm_pkg::HDR_W-1:0];
            replace_active_next = 1'b1;
            patched_flag_next   = 1'b1;
          end else if (current_id == ncipmm_pkg::ID_PMM_TAIL &&
                       b >= ncipmm_pkg::TAIL_MIN_LEN) begin
            replace_start_next  = ncipmm_pkg::HDR_W'(vend -
                                  ncipmm_pkg::SPAN_W'(ncipmm_pkg::PMM_BYTES));
            replace_active_next = 1'b1;
            patched_flag_next   = 1'b1;
          end
          next_header_position_next = vend[ncipmm_pkg::HDR_W-1:0];
          walk_phase_next           = ncipmm_pkg::PH_ID;
        end
      end
    end

    // saturating position count
    if (byte_position < ncipmm_pkg::POS_MAX) begin
      byte_position_next = byte_position + 16'd1;
    end else begin
      byte_position_next = byte_position;
    end

    result.out_byte    = ob;
    result.out_last    = item.end_of_packet;
    result.was_patched = item.end_of_packet & patched_flag_next;
  end

  // state registers; the final byte returns everything to the idle values
  always_ff @(posedge clk) begin
    if (rst || (step && item.end_of_packet)) begin
      byte_position        <= '0;
      payload_end          <= '0;
      packet_qualifies     <= 1'b0;
      walk_phase           <= ncipmm_pkg::PH_ID;
      next_header_position <= ncipmm_pkg::FIRST_PARAM;
      current_id           <= '0;
      replace_start        <= '0;
      replace_active       <= 1'b0;
      patched_flag         <= 1'b0;
    end else if (step) begin
      byte_position        <= byte_position_next;
      payload_end          <= payload_end_next;
      packet_qualifies     <= packet_qualifies_next;
      walk_phase           <= walk_phase_next;
      next_header_position <= next_header_position_next;
      current_id           <= current_id_next;
      replace_start        <= replace_start_next;
      replace_active       <= replace_active_next;
      patched_flag         <= patched_flag_next;
    end
  end

endmodule

// ===== rtl/core/ncipmm_obuf.sv =====
// ----------------------------------------------------------------------------
// ncipmm_obuf: result register with skid stage
// Holds the result item for the downstream side; a second entry catches
// one item while the result register is stalled, so stall upstream is
// a registered signal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncipmm_obuf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ncipmm_pkg::res_item_t push_item,
  output logic                  full,
  output logic                  res_valid,
  input  logic                  res_stall,
  output ncipmm_pkg::res_item_t res_item
);

  logic                  skid_valid;
  ncipmm_pkg::res_item_t skid_item;
  logic                  out_free;

  assign out_free = !res_valid || !res_stall;
  assign full     = skid_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      res_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        res_item <= skid_item;
      end else if (push) begin
        res_item <= push_item;
      end
    end else if (push) begin
      skid_item <= push_item;
    end
  end

endmodule

// ===== rtl/core/nci_set_config_pmm_rewriter.sv =====
// ----------------------------------------------------------------------------
// nci_set_config_pmm_rewriter: NCI SET_CONFIG command PMm rewriter
// Passes a command packet through byte by byte and replaces PMm bytes in
// qualifying SET_CONFIG parameters with the configured value.
// ----------------------------------------------------------------------------
// Result path: a result is registered in the cycle after its item is accepted when the
//   result register is free.
// Throughput: one item per cycle while cmd_stall is low; the walk decision for each byte is a
//   single pass of logic between the packet state and the result register.
// Reset: synchronous rst clears the packet state, patching off, PMm to its
//   default value; no result is valid after reset.
`timescale 1ns / 1ps

module nci_set_config_pmm_rewriter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  ncipmm_pkg::cmd_item_t               cmd_item,
  output logic                                res_valid,
  input  logic                                res_stall,
  output ncipmm_pkg::res_item_t               res_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ncipmm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ncipmm_pkg::PMM_W-1:0]        cfg_data
);

  logic                         patch_enable;
  logic [ncipmm_pkg::PMM_W-1:0] pmm_value;
  logic                         cmd_accept;
  ncipmm_pkg::res_item_t        walk_result;

  assign cfg_ready  = 1'b1;
  assign cmd_accept = cmd_valid && !cmd_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      patch_enable <= 1'b0;
      pmm_value    <= ncipmm_pkg::PMM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (ncipmm_pkg::cfg_reg_t'(cfg_index))
        ncipmm_pkg::REG_PATCH_ENABLE: patch_enable <= cfg_data[0];
        ncipmm_pkg::REG_PMM_VALUE:    pmm_value    <= cfg_data;
        default: ;
      endcase
    end
  end

  ncipmm_walk u_walk (
    .clk          (clk),
    .rst          (rst),
    .step         (cmd_accept),
    .item         (cmd_item),
    .patch_enable (patch_enable),
    .pmm_value    (pmm_value),
    .result       (walk_result)
  );

  ncipmm_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_accept),
    .push_item (walk_result),
    .full      (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  // an accepted item always lands in the result register or the skid entry
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    cmd_accept |=> res_valid)
    else $error("accepted item did not produce a result");

  // the skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> res_valid)
    else $error("skid entry occupied with empty result register");

  // a free downstream empties the skid entry in the following cycle
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    cmd_stall && !res_stall |=> !cmd_stall)
    else $error("skid entry not drained");

  // patch status is reported on the final byte only
  a_patch_on_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.was_patched |-> res_item.out_last)
    else $error("patch flag on a non-final byte");

endmodule
